FILE: src/pfm_pkg.sv
// shared types and constants of the pulse flow meter
`default_nettype none
package pfm_pkg;

	// event kinds carried in the input tuser
	localparam logic [1:0] KIND_PULSE  = 2'd0;
	localparam logic [1:0] KIND_UPDATE = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_CAL     = 2'd0;
	localparam logic [1:0] REG_LOCKOUT = 2'd1;
	localparam logic [1:0] REG_WINDOW  = 2'd2;
	localparam logic [1:0] REG_MAXRATE = 2'd3;

	// register reset values
	localparam logic [23:0] CAL_RST     = 24'd1920;
	localparam logic [31:0] LOCKOUT_RST = 32'd50000;
	localparam logic [31:0] WINDOW_RST  = 32'd1000;
	localparam logic [15:0] MAXRATE_RST = 16'd10000;

	// 60000 * 100 * 256 and 1000 * 256
	localparam logic [31:0] FLOW_SCALE = 32'd1536000000;
	localparam logic [31:0] ML_SCALE   = 32'd256000;

	// shared divider width and iteration counter width
	localparam int DIV_W   = 64;
	localparam int DIV_CW  = $clog2(DIV_W + 1);

	localparam int TOTAL_W = 42;

	// divider status back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// sequencer states
	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_MUL_FLOW = 7'b0000010,
		ST_MUL_DEN  = 7'b0000100,
		ST_MUL_TOT  = 7'b0001000,
		ST_DIV_FLOW = 7'b0010000,
		ST_DIV_TOT  = 7'b0100000,
		ST_DONE     = 7'b1000000
	} state_t;

endpackage
`default_nettype wire

FILE: src/pfm_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module pfm_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [pfm_pkg::DIV_W-1:0] num,
	input  wire logic [pfm_pkg::DIV_W-1:0] den,
	output pfm_pkg::div_stat_t            stat,
	output logic      [pfm_pkg::DIV_W-1:0] quo
);

	localparam int W = pfm_pkg::DIV_W;

	logic [W-1:0]                 rem_q;
	logic [W-1:0]                 quo_q;
	logic [W-1:0]                 den_q;
	logic [pfm_pkg::DIV_CW-1:0]   cnt_q;
	logic                         done_q;

	logic [W:0]   shifted;
	logic [W+1:0] diff;

	// trial subtraction of the divisor from the shifted remainder
	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
	end

	// control: iteration counter and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= pfm_pkg::DIV_CW'(W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == pfm_pkg::DIV_CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!diff[W+1]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quo       = quo_q;

	// done rises in the cycle after the last iteration, unless start comes first
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == pfm_pkg::DIV_CW'(1)) && !start |=> done_q)
		else $error("divider done missing after last iteration");
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cnt_q == '0))
		else $error("divider done while still iterating");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (cnt_q == pfm_pkg::DIV_CW'(W)) && !done_q)
		else $error("divider did not load on start");

endmodule
`default_nettype wire

FILE: src/pulse_flow_meter.sv
// pulse counting flow meter top level with event sequencer
//
// Input stream: each transaction is one event. s_tuser carries the kind
// (pulse edge, update call, clear totals); s_tdata carries the microsecond
// and millisecond timestamps. Every accepted event gives exactly one
// output transaction with flow, total, live pulse count and an update flag.
// Pulse edges, clears and updates whose window has not passed are answered
// without the sequencer: the result is written to the output register at the
// edge that accepts the event. An update that recalculates runs a sequencer
// over one shared 32x32 multiplier (three products, one per cycle) and one
// shared restoring divider (flow, then total); its result is loaded in state
// ST_DONE once the output register is free, and s_tready stays low meanwhile.
// The output register holds a result until m_tready; a new event is taken
// while the held result is being taken in the same cycle.
// Configuration writes through cfg_we/cfg_addr/cfg_wdata take effect at the
// next edge. Reset clears all counts, timestamps and the output valid, and
// loads the register defaults; no clearing pass is needed.
`default_nettype none
module pulse_flow_meter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata,
	// event input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // time_us[31:0], time_ms[63:32]
	input  wire logic [1:0]  s_tuser,  // kind[1:0]
	// result output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,  // flow_rate_x100[15:0], total_ml[57:16],
	                                   // pulse_count[89:58], zero pad[95:90]
	output logic [0:0]       m_tuser   // rate_updated[0]
);

	localparam int TW = pfm_pkg::TOTAL_W;
	localparam int DW = pfm_pkg::DIV_W;

	// configuration registers
	logic [23:0] cal_q;
	logic [31:0] lockout_q;
	logic [31:0] window_q;
	logic [15:0] max_rate_q;

	// meter state
	logic [31:0]   accepted_q;
	logic [31:0]   pulses_last_q;
	logic [31:0]   last_pulse_q;
	logic [31:0]   last_calc_q;
	logic [15:0]   rate_q;
	logic [TW-1:0] total_q;

	// sequencer and operands
	pfm_pkg::state_t state_q;
	logic [31:0]   delta_q;
	logic [31:0]   elapsed_q;
	logic          elapsed_zero_q;
	logic [DW-1:0] num_flow_q;
	logic [DW-1:0] den_flow_q;
	logic [DW-1:0] num_tot_q;
	logic [15:0]   new_rate_q;

	// output register
	logic          m_valid_q;
	logic [15:0]   o_rate_q;
	logic [TW-1:0] o_total_q;
	logic [31:0]   o_count_q;
	logic          o_upd_q;

	logic        in_acc;
	logic        out_free;
	logic [1:0]  kind;
	logic [31:0] t_us;
	logic [31:0] t_ms;
	logic [31:0] since_pulse;
	logic [31:0] since_calc;
	logic        update_due;
	logic [23:0] cal_eff;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;

	logic                div_start;
	logic [DW-1:0]       div_num;
	logic [DW-1:0]       div_den;
	pfm_pkg::div_stat_t  div_stat;
	logic [DW-1:0]       div_quo;

	logic [15:0]   flow_sel;
	logic [TW-1:0] total_sel;

	// input decode and window checks
	always_comb begin
		kind        = s_tuser;
		t_us        = s_tdata[31:0];
		t_ms        = s_tdata[63:32];
		since_pulse = t_us - last_pulse_q;
		since_calc  = t_ms - last_calc_q;
		update_due  = (since_calc >= window_q);
		cal_eff     = (cal_q == '0) ? 24'd1 : cal_q;
	end

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == pfm_pkg::ST_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;

	// shared multiplier, operands chosen by the sequencer
	always_comb begin
		case (state_q)
			pfm_pkg::ST_MUL_FLOW: begin
				mul_a = delta_q;
				mul_b = pfm_pkg::FLOW_SCALE;
			end
			pfm_pkg::ST_MUL_DEN: begin
				mul_a = {8'd0, cal_eff};
				mul_b = elapsed_q;
			end
			pfm_pkg::ST_MUL_TOT: begin
				mul_a = accepted_q;
				mul_b = pfm_pkg::ML_SCALE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// divider start and operand selection
	always_comb begin
		div_start = 1'b0;
		div_num   = num_flow_q;
		div_den   = den_flow_q;
		if (state_q == pfm_pkg::ST_MUL_TOT) begin
			div_start = 1'b1;
		end else if (state_q == pfm_pkg::ST_DIV_FLOW && div_stat.done) begin
			div_start = 1'b1;
			div_num   = num_tot_q;
			div_den   = {{(DW-24){1'b0}}, cal_eff};
		end
	end

	pfm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// flow limit and total saturation on the divider quotient
	always_comb begin
		if (elapsed_zero_q || (div_quo > {{(DW-16){1'b0}}, max_rate_q})) begin
			flow_sel = '0;
		end else begin
			flow_sel = div_quo[15:0];
		end
		if (div_quo[DW-1:TW] != '0) begin
			total_sel = '1;
		end else begin
			total_sel = div_quo[TW-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q      <= pfm_pkg::CAL_RST;
			lockout_q  <= pfm_pkg::LOCKOUT_RST;
			window_q   <= pfm_pkg::WINDOW_RST;
			max_rate_q <= pfm_pkg::MAXRATE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				pfm_pkg::REG_CAL:     cal_q      <= cfg_wdata[23:0];
				pfm_pkg::REG_LOCKOUT: lockout_q  <= cfg_wdata;
				pfm_pkg::REG_WINDOW:  window_q   <= cfg_wdata;
				pfm_pkg::REG_MAXRATE: max_rate_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// sequencer, meter state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= pfm_pkg::ST_IDLE;
			accepted_q    <= '0;
			pulses_last_q <= '0;
			last_pulse_q  <= '0;
			last_calc_q   <= '0;
			rate_q        <= '0;
			total_q       <= '0;
			m_valid_q     <= 1'b0;
		end else begin
			if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				pfm_pkg::ST_IDLE: begin
					if (in_acc) begin
						o_rate_q  <= rate_q;
						o_total_q <= total_q;
						o_count_q <= accepted_q;
						o_upd_q   <= 1'b0;
						m_valid_q <= 1'b1;
						case (kind)
							pfm_pkg::KIND_PULSE: begin
								if (since_pulse > lockout_q) begin
									accepted_q   <= accepted_q + 32'd1;
									last_pulse_q <= t_us;
									o_count_q    <= accepted_q + 32'd1;
								end
							end
							pfm_pkg::KIND_UPDATE: begin
								if (update_due) begin
									// result goes out when the sequence ends
									m_valid_q      <= 1'b0;
									delta_q        <= accepted_q - pulses_last_q;
									elapsed_q      <= since_calc;
									elapsed_zero_q <= (since_calc == '0);
									pulses_last_q  <= accepted_q;
									last_calc_q    <= t_ms;
									state_q        <= pfm_pkg::ST_MUL_FLOW;
								end
							end
							pfm_pkg::KIND_CLEAR: begin
								accepted_q    <= '0;
								pulses_last_q <= '0;
								rate_q        <= '0;
								total_q       <= '0;
								o_rate_q      <= '0;
								o_total_q     <= '0;
								o_count_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				pfm_pkg::ST_MUL_FLOW: begin
					num_flow_q <= mul_p;
					state_q    <= pfm_pkg::ST_MUL_DEN;
				end
				pfm_pkg::ST_MUL_DEN: begin
					den_flow_q <= mul_p;
					state_q    <= pfm_pkg::ST_MUL_TOT;
				end
				pfm_pkg::ST_MUL_TOT: begin
					num_tot_q <= mul_p;
					state_q   <= pfm_pkg::ST_DIV_FLOW;
				end
				pfm_pkg::ST_DIV_FLOW: begin
					if (div_stat.done) begin
						new_rate_q <= flow_sel;
						state_q    <= pfm_pkg::ST_DIV_TOT;
					end
				end
				pfm_pkg::ST_DIV_TOT: begin
					if (div_stat.done) begin
						rate_q  <= new_rate_q;
						total_q <= total_sel;
						state_q <= pfm_pkg::ST_DONE;
					end
				end
				pfm_pkg::ST_DONE: begin
					if (out_free) begin
						o_rate_q  <= rate_q;
						o_total_q <= total_q;
						o_count_q <= accepted_q;
						o_upd_q   <= 1'b1;
						m_valid_q <= 1'b1;
						state_q   <= pfm_pkg::ST_IDLE;
					end
				end
				default: state_q <= pfm_pkg::ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, o_count_q, o_total_q, o_rate_q};
	assign m_tuser  = o_upd_q;

	// no new event while a recalculation is in flight
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != pfm_pkg::ST_IDLE) |-> !s_tready)
		else $error("event accepted during recalculation");
	// the divider only finishes in a divide state
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |->
			(state_q == pfm_pkg::ST_DIV_FLOW) || (state_q == pfm_pkg::ST_DIV_TOT))
		else $error("divider done outside divide states");
	// a recalculated flow never exceeds the limit
	a_flow_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && o_upd_q |-> (o_rate_q <= max_rate_q))
		else $error("reported flow above limit");
	// a result does not appear while the divider runs
	a_no_out_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> !$rose(m_valid_q))
		else $error("result loaded while divider busy");

endmodule
`default_nettype wire

FILE: tb/sv/pulse_flow_meter_tb.sv
// testbench of the pulse flow meter: event streams checked against a predicted meter state
module pulse_flow_meter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 8;
	localparam int MAX_GAP       = 12;
	localparam int SETTLE_CYCLES = 160;
	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_AFTER    = 150;
	localparam int HOLD_CYCLES   = 400;
	localparam int NUM_PHASES    = 8;

	// the one kind value that changes no meter state
	localparam logic [1:0]  KIND_UNUSED   = 2'd3;
	// 60000 ms/min * 100 * 256 fraction scale, and 1000 ml * 256
	localparam logic [63:0] FLOW_FACTOR   = 64'd1536000000;
	localparam logic [63:0] VOLUME_FACTOR = 64'd256000;
	localparam logic [63:0] TOTAL_MAX     = 64'h3FF_FFFF_FFFF;

	typedef struct {
		logic [15:0] flow;
		logic [41:0] total;
		logic [31:0] count;
		logic        updated;
	} meter_reading_t;

	// predicted meter state and the readings still due from the block
	class meter_tracker;
		logic [23:0] cal;
		logic [31:0] lockout;
		logic [31:0] window;
		logic [15:0] max_rate;
		logic [31:0] pulses;
		logic [31:0] pulses_at_calc;
		logic [31:0] last_pulse_us;
		logic [31:0] last_calc_ms;
		logic [15:0] rate;
		logic [41:0] total;
		meter_reading_t due_readings[$];
		int mismatches;

		function new();
			cal            = 24'd1920;
			lockout        = 32'd50000;
			window         = 32'd1000;
			max_rate       = 16'd10000;
			pulses         = '0;
			pulses_at_calc = '0;
			last_pulse_us  = '0;
			last_calc_ms   = '0;
			rate           = '0;
			total          = '0;
			mismatches     = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				pfm_pkg::REG_CAL:     cal = value[23:0];
				pfm_pkg::REG_LOCKOUT: lockout = value;
				pfm_pkg::REG_WINDOW:  window = value;
				pfm_pkg::REG_MAXRATE: max_rate = value[15:0];
				default: ;
			endcase
		endfunction

		// advance the meter by one accepted event and queue its reading
		function void log_event(logic [1:0] kind, logic [31:0] t_us,
				logic [31:0] t_ms);
			logic [31:0] since_us;
			logic [31:0] elapsed;
			logic [31:0] fresh;
			logic [63:0] cal_eff;
			logic [63:0] num;
			logic [63:0] den;
			logic [63:0] flow;
			logic [63:0] vol;
			meter_reading_t r;
			r.updated = 1'b0;
			case (kind)
				pfm_pkg::KIND_PULSE: begin
					since_us = t_us - last_pulse_us;
					if (since_us > lockout) begin
						pulses = pulses + 32'd1;
						last_pulse_us = t_us;
					end
				end
				pfm_pkg::KIND_UPDATE: begin
					elapsed = t_ms - last_calc_ms;
					if (elapsed >= window) begin
						// zero calibration counts as one
						cal_eff = (cal == 24'd0) ? 64'd1 : {40'd0, cal};
						fresh = pulses - pulses_at_calc;
						num = {32'd0, fresh} * FLOW_FACTOR;
						den = cal_eff * {32'd0, elapsed};
						flow = (elapsed == 32'd0) ? 64'd0 : num / den;
						// implausible flow is a sensor error
						if (flow > {48'd0, max_rate})
							flow = 64'd0;
						rate = flow[15:0];
						vol = ({32'd0, pulses} * VOLUME_FACTOR) / cal_eff;
						total = (vol > TOTAL_MAX) ? TOTAL_MAX[41:0] : vol[41:0];
						pulses_at_calc = pulses;
						last_calc_ms = t_ms;
						r.updated = 1'b1;
					end
				end
				pfm_pkg::KIND_CLEAR: begin
					// timestamps survive a clear
					pulses         = '0;
					pulses_at_calc = '0;
					rate           = '0;
					total          = '0;
				end
				default: ;
			endcase
			r.flow  = rate;
			r.total = total;
			r.count = pulses;
			due_readings.push_back(r);
		endfunction

		function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d",
					$time, name, exp_v, act_v);
				mismatches++;
			end
		endfunction

		// compare one result transaction with the oldest due reading
		function void check_reading(logic [95:0] data, logic [0:0] user);
			meter_reading_t e;
			if (due_readings.size() == 0) begin
				$display({"%0t: unexpected result: expected none, ",
					"actual flow %0d total %0d count %0d updated %0d"},
					$time, data[15:0], data[57:16], data[89:58], user[0]);
				mismatches++;
				return;
			end
			e = due_readings.pop_front();
			check_field("flow_rate_x100", e.flow, data[15:0]);
			check_field("total_ml", e.total, data[57:16]);
			check_field("pulse_count", e.count, data[89:58]);
			check_field("rate_updated", e.updated, user[0]);
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_addr  = '0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;   // time_us[31:0], time_ms[63:32]
	logic [1:0]  s_tuser   = '0;   // kind[1:0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [95:0] m_tdata;          // flow_rate_x100[15:0], total_ml[57:16], pulse_count[89:58]
	logic [0:0]  m_tuser;          // rate_updated[0]

	meter_tracker tracker;
	logic [31:0]  gen_us = '0;
	logic [31:0]  gen_ms = '0;
	bit           send_burst = 1'b0;
	int           idle_cycles = 0;

	pulse_flow_meter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// offer one event, with a random lead-in gap, until accepted
	task automatic send_event(input logic [1:0] kind, input logic [31:0] t_us,
			input logic [31:0] t_ms);
		int gap;
		if ($urandom_range(0, 19) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {t_ms, t_us};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.log_event(kind, t_us, t_ms);
	endtask

	// stop offering and let every due reading come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tracker.due_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all four registers on consecutive edges
	task automatic set_config(input logic [23:0] cal, input logic [31:0] lockout,
			input logic [31:0] window, input logic [15:0] max_rate);
		cfg_we    <= 1'b1;
		cfg_addr  <= pfm_pkg::REG_CAL;
		cfg_wdata <= {8'd0, cal};
		@(posedge clk);
		cfg_addr  <= pfm_pkg::REG_LOCKOUT;
		cfg_wdata <= lockout;
		@(posedge clk);
		cfg_addr  <= pfm_pkg::REG_WINDOW;
		cfg_wdata <= window;
		@(posedge clk);
		cfg_addr  <= pfm_pkg::REG_MAXRATE;
		cfg_wdata <= {16'd0, max_rate};
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.write_reg(pfm_pkg::REG_CAL, {8'd0, cal});
		tracker.write_reg(pfm_pkg::REG_LOCKOUT, lockout);
		tracker.write_reg(pfm_pkg::REG_WINDOW, window);
		tracker.write_reg(pfm_pkg::REG_MAXRATE, {16'd0, max_rate});
	endtask

	// mostly plausible sensor timing around the lockout and window, some noise
	task automatic send_random();
		logic [1:0]  kind;
		logic [31:0] step;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			case ($urandom_range(0, 3))
				0: step = tracker.lockout;
				1: step = tracker.lockout + 32'd1;
				2: step = $urandom_range(0, tracker.lockout);
				default: step = tracker.lockout + $urandom_range(1, 40000);
			endcase
			gen_us += step;
			gen_ms += step / 1000;
			send_event(pfm_pkg::KIND_PULSE, gen_us, gen_ms);
		end else if (pick < 85) begin
			case ($urandom_range(0, 3))
				0: step = tracker.window - 32'd1;
				1: step = tracker.window;
				2: step = $urandom_range(0, tracker.window);
				default: step = tracker.window + $urandom_range(1, 500);
			endcase
			gen_ms += step;
			gen_us += step * 1000;
			send_event(pfm_pkg::KIND_UPDATE, gen_us, gen_ms);
		end else if (pick < 90) begin
			send_event(pfm_pkg::KIND_CLEAR, $urandom, $urandom);
		end else if (pick < 93) begin
			send_event(KIND_UNUSED, $urandom, $urandom);
		end else begin
			kind = 2'($urandom_range(0, 3));
			send_event(kind, $urandom, $urandom);
		end
	endtask

	// lockout edges, wrapping times, window edges, clear and the unused kind
	task automatic run_directed();
		send_event(pfm_pkg::KIND_PULSE, 32'd0, 32'd0);
		send_event(pfm_pkg::KIND_PULSE, 32'd50000, 32'hFFFF_FFFF);
		send_event(pfm_pkg::KIND_PULSE, 32'd50001, 32'd0);
		send_event(pfm_pkg::KIND_PULSE, 32'd100001, 32'd0);
		send_event(pfm_pkg::KIND_PULSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(pfm_pkg::KIND_PULSE, 32'd50000, 32'd0);
		send_event(pfm_pkg::KIND_UPDATE, 32'hFFFF_FFFF, 32'd999);
		send_event(pfm_pkg::KIND_UPDATE, 32'd0, 32'd1000);
		send_event(pfm_pkg::KIND_PULSE, 32'd150001, 32'd1100);
		send_event(pfm_pkg::KIND_UPDATE, 32'd0, 32'hFFFF_FFFF);
		send_event(pfm_pkg::KIND_UPDATE, 32'd0, 32'd998);
		send_event(pfm_pkg::KIND_UPDATE, 32'd0, 32'd999);
		send_event(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(pfm_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(pfm_pkg::KIND_UPDATE, 32'd0, 32'd2000);
		send_event(pfm_pkg::KIND_PULSE, 32'd150001, 32'd0);
		send_event(pfm_pkg::KIND_PULSE, 32'd200002, 32'd0);
		send_event(pfm_pkg::KIND_UPDATE, 32'hFFFF_FFFF, 32'd3000);
	endtask

	// result side with random stalls and one long hold-off
	initial begin
		int gap;
		int seen;
		bit burst;
		seen  = 0;
		burst = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				burst = !burst;
			gap = (seen == HOLD_AFTER) ? HOLD_CYCLES : (burst ? 0 : $urandom_range(0, MAX_GAP));
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			tracker.check_reading(m_tdata, m_tuser);
			seen++;
		end
	end

	// reset, directed events, then random phases over several settings
	initial begin
		logic [23:0] cal_v;
		logic [31:0] lock_v;
		logic [31:0] win_v;
		logic [15:0] max_v;
		int ph;
		int n;
		int i;
		tracker = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					cal_v = 24'd1920; lock_v = 32'd50000; win_v = 32'd1000; max_v = 16'd10000;
					// start close to the wrap of both timers
					gen_us = 32'hFFF0_0000;
					gen_ms = 32'hFFFF_F000;
					n = 70;
				end
				1: begin
					cal_v = 24'hFF_FFFF; lock_v = 32'd0; win_v = 32'd1; max_v = 16'hFFFF;
					n = 50;
				end
				2: begin
					cal_v = 24'd1; lock_v = 32'hFFFF_FFFF; win_v = 32'hFFFF_FFFF; max_v = 16'd0;
					n = 20;
				end
				3: begin
					// zero calibration and zero window
					cal_v = 24'd0; lock_v = 32'd1000; win_v = 32'd0; max_v = 16'hFFFF;
					n = 50;
				end
				4: begin
					cal_v  = 24'($urandom_range(1000, 4000));
					lock_v = $urandom_range(20000, 80000);
					win_v  = $urandom_range(500, 2000);
					max_v  = 16'($urandom_range(5000, 20000));
					n = 80;
				end
				5: begin
					cal_v = 24'd256; lock_v = 32'd10; win_v = 32'd50; max_v = 16'hFFFF;
					n = 60;
				end
				6: begin
					cal_v  = 24'($urandom_range(1, 24'hFF_FFFF));
					lock_v = $urandom;
					win_v  = $urandom;
					max_v  = 16'($urandom_range(0, 16'hFFFF));
					n = 30;
				end
				default: begin
					cal_v = 24'd1920; lock_v = 32'd50000; win_v = 32'd1000; max_v = 16'd10000;
					n = 70;
				end
			endcase
			set_config(cal_v, lock_v, win_v, max_v);
			for (i = 0; i < n; i++) begin
				// sender pause until the block has answered everything
				if (ph == 4 && i == 40)
					wait_drained();
				send_random();
			end
		end
		wait_drained();
		if (tracker.mismatches == 0 && tracker.due_readings.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: pulse_flow_meter.f
src/pfm_pkg.sv
src/pfm_div.sv
src/pulse_flow_meter.sv
tb/sv/pulse_flow_meter_tb.sv
